[rtl/dpq_pkg.sv]
`timescale 1ns / 1ps
package dpq_pkg;

    // Operation codes carried on the command field.
    localparam logic [1:0] CMD_INSERT  = 2'd0;
    localparam logic [1:0] CMD_POP_MIN = 2'd1;
    localparam logic [1:0] CMD_POP_MAX = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Read address selection for the entry memory.
    typedef enum logic [1:0] {
        RD_MID,
        RD_SHIFT,
        RD_FIRST,
        RD_LAST
    } t_rd_sel;

    // Write source and address selection for the entry memory.
    typedef enum logic [1:0] {
        WR_FOUND,
        WR_SHIFT,
        WR_NEW
    } t_wr_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       rd_en;
        t_rd_sel    rd_sel;
        logic       wr_en;
        t_wr_sel    wr_sel;
        logic       step;
        logic       shift_init;
        logic       shift_dec;
        logic       cnt_inc;
        logic       pop_take;
        logic       set_status;
        logic [1:0] status;
        logic       out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] cmd;
        logic       search_done;
        logic       found;
        logic       full;
        logic       empty;
        logic       shift_done;
        logic       out_busy;
    } t_dp_status;

endpackage

[rtl/double_ended_priority_queue_core.sv]
`timescale 1ns / 1ps
// Double-ended priority queue of up to CAPACITY unique signed keys, each with a
// payload, kept sorted in a circular buffer in one memory. One word is handled at
// a time and each gives one result word. An insert runs a binary search with one
// memory read per step over about log2(count) steps; a new key then shifts every
// larger entry up by one slot through the single memory port. No clearing pass is
// needed after reset.
module double_ended_priority_queue_core #(
    parameter int CAPACITY = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_cmd,
    input  logic signed [31:0] i_item_key,
    input  logic signed [31:0] i_item_payload,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_popped_payload,
    output logic [1:0]         o_status
);
    import dpq_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_st;

    // Sequencing of search, shift and pop steps.
    dpq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_st    (dp_st),
        .o_cmd   (dp_cmd)
    );

    // Entry memory, pointers and result register.
    dpq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .o_st             (dp_st),
        .i_in_cmd         (i_cmd),
        .i_in_key         (i_item_key),
        .i_in_payload     (i_item_payload),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_popped_payload (o_popped_payload),
        .o_status         (o_status)
    );

endmodule

[rtl/dpq_ctrl.sv]
`timescale 1ns / 1ps
module dpq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  dpq_pkg::t_dp_status i_st,
    output dpq_pkg::t_dp_cmd    o_cmd
);
    import dpq_pkg::*;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DEC       = 4'd1;
    localparam logic [3:0] S_SRCH      = 4'd2;
    localparam logic [3:0] S_CMP       = 4'd3;
    localparam logic [3:0] S_SHIFT_CHK = 4'd4;
    localparam logic [3:0] S_SHIFT_WR  = 4'd5;
    localparam logic [3:0] S_WR_NEW    = 4'd6;
    localparam logic [3:0] S_WR_FOUND  = 4'd7;
    localparam logic [3:0] S_POP_RD    = 4'd8;
    localparam logic [3:0] S_POP_TAKE  = 4'd9;
    localparam logic [3:0] S_FIN       = 4'd10;

    logic [3:0] r_state, n_state;

    // A new word is taken only when idle and the result register is empty or being taken.
    assign o_ready = (r_state == S_IDLE) && !i_st.out_busy;

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_cmd.rd_sel = RD_MID;
        o_cmd.wr_sel = WR_NEW;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    o_cmd.load = 1'b1;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                priority if (i_st.cmd == CMD_INSERT) begin
                    n_state = S_SRCH;
                end else if (i_st.cmd == CMD_POP_MIN || i_st.cmd == CMD_POP_MAX) begin
                    if (i_st.empty) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status = ST_EMPTY;
                        n_state = S_FIN;
                    end else begin
                        n_state = S_POP_RD;
                    end
                end else begin
                    n_state = S_FIN;
                end
            end
            S_SRCH: begin
                if (i_st.search_done) begin
                    if (i_st.full) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status = ST_FULL;
                        n_state = S_FIN;
                    end else begin
                        o_cmd.shift_init = 1'b1;
                        n_state = S_SHIFT_CHK;
                    end
                end else begin
                    o_cmd.rd_en = 1'b1;
                    o_cmd.rd_sel = RD_MID;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (i_st.found) begin
                    n_state = S_WR_FOUND;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state = S_SRCH;
                end
            end
            S_SHIFT_CHK: begin
                if (i_st.shift_done) begin
                    n_state = S_WR_NEW;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    o_cmd.rd_sel = RD_SHIFT;
                    n_state = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                o_cmd.wr_en = 1'b1;
                o_cmd.wr_sel = WR_SHIFT;
                o_cmd.shift_dec = 1'b1;
                n_state = S_SHIFT_CHK;
            end
            S_WR_NEW: begin
                o_cmd.wr_en = 1'b1;
                o_cmd.wr_sel = WR_NEW;
                o_cmd.cnt_inc = 1'b1;
                n_state = S_FIN;
            end
            S_WR_FOUND: begin
                o_cmd.wr_en = 1'b1;
                o_cmd.wr_sel = WR_FOUND;
                n_state = S_FIN;
            end
            S_POP_RD: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.rd_sel = (i_st.cmd == CMD_POP_MIN) ? RD_FIRST : RD_LAST;
                n_state = S_POP_TAKE;
            end
            S_POP_TAKE: begin
                o_cmd.pop_take = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!i_st.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[rtl/dpq_dp.sv]
`timescale 1ns / 1ps
module dpq_dp #(
    parameter int CAPACITY = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  dpq_pkg::t_dp_cmd      i_cmd,
    output dpq_pkg::t_dp_status   o_st,
    input  logic [1:0]            i_in_cmd,
    input  logic signed [31:0]    i_in_key,
    input  logic signed [31:0]    i_in_payload,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic signed [31:0]    o_popped_payload,
    output logic [1:0]            o_status
);
    import dpq_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW:0] CAP_X = (CW + 1)'(CAPACITY);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);

    // Entry memory: key in the upper half, payload in the lower half.
    logic [63:0] r_mem [CAPACITY];
    logic [63:0] r_rd;

    logic [1:0]           r_cmd;
    logic signed [31:0]   r_key;
    logic signed [31:0]   r_pay;
    logic [AW-1:0]        r_head;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        r_lo, r_hi, r_mid, r_idx;
    logic signed [31:0]   r_res;
    logic [1:0]           r_res_st;
    logic                 r_out_valid;
    logic signed [31:0]   r_out_pay;
    logic [1:0]           r_out_st;

    logic [CW-1:0]        mid;
    logic [CW:0]          mid_sum;
    logic [CW-1:0]        rd_log, wr_log;
    logic [AW-1:0]        rd_addr, wr_addr;
    logic [63:0]          wr_data;
    logic signed [31:0]   rd_key;

    // Maps a logical slot onto the circular buffer.
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                           input logic [CW-1:0] lg);
        logic [CW:0] s;
        s = (CW + 1)'(head) + (CW + 1)'(lg);
        if (s >= CAP_X) begin
            s = s - CAP_X;
        end
        return s[AW-1:0];
    endfunction

    assign mid_sum = (CW + 1)'(r_lo) + (CW + 1)'(r_hi);
    assign mid     = mid_sum[CW:1];
    assign rd_key  = $signed(r_rd[63:32]);

    // Read address selection.
    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_MID:   rd_log = mid;
            RD_SHIFT: rd_log = r_idx - CW'(1);
            RD_FIRST: rd_log = '0;
            RD_LAST:  rd_log = r_count - CW'(1);
            default:  rd_log = '0;
        endcase
    end
    assign rd_addr = phys(r_head, rd_log);

    // Write address and data selection.
    always_comb begin
        unique case (i_cmd.wr_sel)
            WR_FOUND: begin
                wr_log  = r_mid;
                wr_data = {r_key, r_pay};
            end
            WR_SHIFT: begin
                wr_log  = r_idx;
                wr_data = r_rd;
            end
            WR_NEW: begin
                wr_log  = r_lo;
                wr_data = {r_key, r_pay};
            end
            default: begin
                wr_log  = r_lo;
                wr_data = {r_key, r_pay};
            end
        endcase
    end
    assign wr_addr = phys(r_head, wr_log);

    // Entry memory with registered read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    // Request word, search bounds and shift index.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= i_in_cmd;
            r_key <= i_in_key;
            r_pay <= i_in_payload;
            r_lo  <= '0;
            r_hi  <= r_count;
            r_res <= '0;
            r_res_st <= ST_OK;
        end
        if (i_cmd.rd_en) begin
            r_mid <= mid;
        end
        if (i_cmd.step) begin
            if (rd_key < r_key) begin
                r_lo <= r_mid + CW'(1);
            end else begin
                r_hi <= r_mid;
            end
        end
        if (i_cmd.shift_init) begin
            r_idx <= r_count;
        end else if (i_cmd.shift_dec) begin
            r_idx <= r_idx - CW'(1);
        end
        if (i_cmd.set_status) begin
            r_res_st <= i_cmd.status;
        end
        if (i_cmd.pop_take) begin
            r_res <= $signed(r_rd[31:0]);
        end
    end

    // Occupancy: head moves on pop-min, count follows inserts and pops.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.pop_take) begin
                r_count <= r_count - CW'(1);
                if (r_cmd == CMD_POP_MIN) begin
                    r_head <= (r_head == LAST_SLOT) ? '0 : r_head + AW'(1);
                end
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_pay <= r_res;
            r_out_st  <= r_res_st;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_popped_payload = r_out_pay;
    assign o_status         = r_out_st;

    // Status toward the controller.
    assign o_st.cmd         = r_cmd;
    assign o_st.search_done = (r_lo >= r_hi);
    assign o_st.found       = (rd_key == r_key);
    assign o_st.full        = (r_count == CAP_C);
    assign o_st.empty       = (r_count == '0);
    assign o_st.shift_done  = (r_idx == r_lo);
    assign o_st.out_busy    = r_out_valid && !i_ready;

endmodule

[rtl/dpq_checker.sv]
`timescale 1ns / 1ps
module dpq_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [31:0] o_popped_payload,
    input logic [1:0]         o_status
);
    import dpq_pkg::*;

    // A waiting result is held until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_popped_payload) && $stable(o_status))
        else $error("result word changed while stalled");

    // No new word is taken while a result is still waiting to be taken.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready)
        else $error("input accepted while a result is pending");

    // Failed operations return a zero payload.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_EMPTY || o_status == ST_FULL) |-> o_popped_payload == 0)
        else $error("nonzero payload on empty or full status");

    // An accepted word never produces a result in the next cycle.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_valid)
        else $error("result appeared too early");

endmodule

bind double_ended_priority_queue_core dpq_checker u_dpq_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_ready          (o_ready),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_popped_payload (o_popped_payload),
    .o_status         (o_status)
);

[tb/double_ended_priority_queue_core_tb.sv]
`timescale 1ns / 1ps
module double_ended_priority_queue_core_tb;
    import dpq_pkg::*;

    localparam int CAP = 256;

    // Command code that the block ignores.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Expected result of one word.
    typedef struct {
        logic signed [31:0] payload;
        logic [1:0]         status;
    } t_dpq_result;

    // Sorted store of the predicted queue contents and the pending results.
    class dpq_scoreboard;
        logic signed [31:0] keys[$];
        logic signed [31:0] pays[$];
        t_dpq_result        pending[$];
        int                 errors;
        int                 checked;

        // Prints one mismatch line and counts it.
        task report(string msg);
            errors++;
            $display("ERROR: %s", msg);
        endtask

        // Applies one accepted word to the predicted store.
        function void note_word(logic [1:0] cmd, logic signed [31:0] key,
                                logic signed [31:0] pay);
            t_dpq_result r;
            int pos;
            r.payload = 0;
            r.status = ST_OK;
            if (cmd == CMD_INSERT) begin
                pos = 0;
                while (pos < keys.size() && keys[pos] < key) pos++;
                if (pos < keys.size() && keys[pos] == key) begin
                    pays[pos] = pay;
                end else if (keys.size() >= CAP) begin
                    r.status = ST_FULL;
                end else begin
                    keys.insert(pos, key);
                    pays.insert(pos, pay);
                end
            end else if (cmd == CMD_POP_MIN || cmd == CMD_POP_MAX) begin
                if (keys.size() == 0) begin
                    r.status = ST_EMPTY;
                end else if (cmd == CMD_POP_MIN) begin
                    r.payload = pays.pop_front();
                    void'(keys.pop_front());
                end else begin
                    r.payload = pays.pop_back();
                    void'(keys.pop_back());
                end
            end
            pending.push_back(r);
        endfunction

        // Compares one result word with the oldest expectation.
        task check_result(logic signed [31:0] pay, logic [1:0] st);
            t_dpq_result r;
            checked++;
            if (pending.size() == 0) begin
                report($sformatf("result with none expected (payload %0d)", pay));
                return;
            end
            r = pending.pop_front();
            if (pay !== r.payload || st !== r.status) begin
                report($sformatf("got payload %0d status %0d, expected %0d status %0d",
                                 pay, st, r.payload, r.status));
            end
        endtask
    endclass

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_valid = 0;
    logic               o_ready;
    logic [1:0]         i_cmd = CMD_INSERT;
    logic signed [31:0] i_item_key = 0;
    logic signed [31:0] i_item_payload = 0;
    logic               o_valid;
    logic               i_ready = 0;
    logic signed [31:0] o_popped_payload;
    logic [1:0]         o_status;

    dpq_scoreboard sb = new();
    int  hold_off = 0;
    int  words_sent = 0;
    int  burst_left = 0;
    logic sink_on = 0;

    double_ended_priority_queue_core #(.CAPACITY(CAP)) dut (.*);

    always #1 i_clk = ~i_clk;

    // Values as they stood just before each rising edge.
    clocking cb @(posedge i_clk);
        input i_rst_n, i_valid, o_ready, i_cmd, i_item_key, i_item_payload,
              o_valid, i_ready, o_popped_payload, o_status;
    endclocking

    // Sample both handshakes at the rising edge.
    always @(cb) begin
        if (cb.i_rst_n && cb.i_valid && cb.o_ready)
            sb.note_word(cb.i_cmd, cb.i_item_key, cb.i_item_payload);
        if (cb.i_rst_n && cb.o_valid && cb.i_ready)
            sb.check_result(cb.o_popped_payload, cb.o_status);
    end

    // Receiver: stalls on its own pattern, or holds off entirely when asked.
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_ready <= 0;
        end else begin
            if ($urandom_range(0, 63) == 0) sink_on <= ~sink_on;
            i_ready <= sink_on ? 1'b1 : ($urandom_range(0, 3) == 0);
        end
    end

    // Offers one word and waits until it is accepted.
    task automatic send_word(logic [1:0] cmd, logic signed [31:0] key,
                             logic signed [31:0] pay);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
            repeat (gap) begin
                i_valid <= 0;
                @(negedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1;
        i_cmd <= cmd;
        i_item_key <= key;
        i_item_payload <= pay;
        @(cb);
        while (!cb.o_ready) @(cb);
        words_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 0;
        while (sb.pending.size() != 0) @(negedge i_clk);
    endtask

    // Keys mostly from a small pool so duplicates recur, with extremes and some random keys.
    function automatic logic signed [31:0] pick_key(int span);
        case ($urandom_range(0, 9))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return $urandom;
            default: return $signed($urandom_range(0, span)) - span / 2;
        endcase
    endfunction

    initial begin
        int i, n;
        logic [1:0] c;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // Directed: empty pops, extremes, duplicate key, unused command.
        send_word(CMD_POP_MIN, 0, 0);
        send_word(CMD_POP_MAX, 0, 0);
        send_word(CMD_INSERT, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_word(CMD_INSERT, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_word(CMD_INSERT, 0, -1);
        send_word(CMD_INSERT, -1, 32'sh5555_5555);
        send_word(CMD_INSERT, 0, 32'shAAAA_AAAA);
        send_word(CMD_UNUSED, 32'sh1234_5678, -1);
        send_word(CMD_POP_MIN, -1, -1);
        send_word(CMD_POP_MAX, -1, -1);
        send_word(CMD_POP_MIN, 0, 0);
        send_word(CMD_POP_MAX, 0, 0);
        send_word(CMD_POP_MIN, 0, 0);
        send_word(CMD_POP_MAX, 0, 0);
        wait_drained();

        // Fill to capacity while the receiver holds off, then overflow.
        hold_off = 400;
        for (i = 0; i < CAP; i++) send_word(CMD_INSERT, i * 7 - 900, $urandom);
        send_word(CMD_INSERT, 32'sh7FFF_FFFF, 5);
        send_word(CMD_INSERT, 0 * 7 - 900, 77);
        send_word(CMD_POP_MAX, 0, 0);
        send_word(CMD_INSERT, 32'sh8000_0000, $urandom);
        send_word(CMD_INSERT, 32'sh7FFF_FFFF, $urandom);
        wait_drained();
        for (i = 0; i < CAP + 2; i++)
            send_word($urandom_range(0, 1) ? CMD_POP_MIN : CMD_POP_MAX, $urandom, $urandom);
        wait_drained();

        // Random traffic, mostly small occupancy.
        for (n = 0; n < 750; n++) begin
            i = $urandom_range(0, 99);
            c = (i < 55) ? CMD_INSERT : (i < 76) ? CMD_POP_MIN :
                (i < 97) ? CMD_POP_MAX : CMD_UNUSED;
            send_word(c, pick_key(60), $urandom);
            if (n == 400) wait_drained();
        end
        wait_drained();
        repeat (50) @(negedge i_clk);
        $display("Covered %0d words: empty pops, full drops, duplicate keys, extreme keys.",
                 words_sent);
        $display("Checked %0d results under random stalls and a long receiver hold-off.",
                 sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("FAIL");
        $finish;
    end

endmodule
